// File: rtl/core/raycast_wall_column_span_top_macros.svh
// Assertion macros shared by the raycaster column block.
`ifndef RAYCAST_WALL_COLUMN_SPAN_TOP_MACROS_SVH
`define RAYCAST_WALL_COLUMN_SPAN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rcwc_pkg.sv
package rcwc_pkg;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam logic [23:0] MIN_DIST = 24'd6554;

  localparam logic OP_COLUMN = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [1:0] CFG_CEILING = 2'd0;
  localparam logic [1:0] CFG_FLOOR   = 2'd1;
  localparam logic [1:0] CFG_PITCH   = 2'd2;

  typedef enum logic [1:0] {
    KIND_COLUMN  = 2'd0,
    KIND_CEILING = 2'd1,
    KIND_WALL    = 2'd2,
    KIND_FLOOR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_H,
    ST_DIV_STEP,
    ST_MUL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_res_t;

endpackage

// File: rtl/core/rcwc_in_if.sv
interface rcwc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [23:0] wall_distance;
  logic [15:0] wall_hit_fraction;
  logic        hit_side;
  logic        ray_dir_x_positive;
  logic        ray_dir_y_positive;

  modport source (
    output valid, opcode, wall_distance, wall_hit_fraction, hit_side,
    output ray_dir_x_positive, ray_dir_y_positive,
    input  ready
  );

  modport sink (
    input  valid, opcode, wall_distance, wall_hit_fraction, hit_side,
    input  ray_dir_x_positive, ray_dir_y_positive,
    output ready
  );
endinterface

// File: rtl/core/rcwc_out_if.sv
interface rcwc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] color;
  logic [1:0]  texture_select;
  logic [5:0]  texel_column;
  logic [5:0]  texel_row;
  logic [23:0] depth_clamped;
  logic [9:0]  span_start;
  logic [8:0]  span_end;
  logic [8:0]  pixel_row;
  logic        last_row;

  modport source (
    output valid, kind, color, texture_select, texel_column, texel_row,
    output depth_clamped, span_start, span_end, pixel_row, last_row,
    input  ready
  );

  modport sink (
    input  valid, kind, color, texture_select, texel_column, texel_row,
    input  depth_clamped, span_start, span_end, pixel_row, last_row,
    output ready
  );
endinterface

// File: rtl/core/rcwc_div.sv
module rcwc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rcwc_pkg::div_req_t  req,
  output rcwc_pkg::div_res_t  res
);

  logic                        busy_r;
  logic                        done_r;
  logic [rcwc_pkg::DIV_CW-1:0] cnt_r;
  logic [rcwc_pkg::DIV_NW-1:0] quo_r;
  logic [rcwc_pkg::DIV_DW-1:0] rem_r;
  logic [rcwc_pkg::DIV_DW-1:0] div_r;

  logic [rcwc_pkg::DIV_DW:0]   trial;
  logic [rcwc_pkg::DIV_DW:0]   diff;
  logic                        fits;

  always_comb begin
    trial = {rem_r, quo_r[rcwc_pkg::DIV_NW-1]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rcwc_pkg::DIV_CW'(rcwc_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[rcwc_pkg::DIV_NW-2:0], fits};
      rem_r <= fits ? diff[rcwc_pkg::DIV_DW-1:0] : trial[rcwc_pkg::DIV_DW-1:0];
    end
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

// File: rtl/core/raycast_wall_column_span_top.sv
// Textured wall column generator. A column item loads one screen column and
// ends with the column info item in the output register. The line height
// and the texture step come from two passes through one shared restoring
// divider. Each pass takes one quotient bit per cycle for 32 bits, then
// hands the quotient over. A multiply state for the texture start position
// and a state to load the result follow; the load waits for a free output
// register. When the line height is zero the second pass is skipped. A
// pixel item yields the next row, top to bottom, as ceiling, wall texel or
// floor. Items are accepted only while no column is being worked on and the
// output register is free or being emptied.

`include "raycast_wall_column_span_top_macros.svh"

module raycast_wall_column_span_top #(
  parameter int SCREEN_HEIGHT = 512,
  parameter int TEX_ROWS      = 64,
  parameter int TEX_COLUMNS   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  rcwc_in_if.sink           in_item,
  rcwc_out_if.source        out_item
);

  localparam int RW = $clog2(SCREEN_HEIGHT + 1);
  localparam int HW = $clog2(SCREEN_HEIGHT) + 4;
  localparam int SW = ($clog2(SCREEN_HEIGHT) + 6 > 13) ? $clog2(SCREEN_HEIGHT) + 6 : 13;
  localparam logic [31:0] H_DIVIDEND    = 32'(SCREEN_HEIGHT) << 16;
  localparam logic [31:0] STEP_DIVIDEND = 32'(TEX_ROWS) << 16;
  localparam logic signed [SW-1:0] SH_S     = SW'(SCREEN_HEIGHT);
  localparam logic signed [SW-1:0] CENTRE_S = SW'(SCREEN_HEIGHT / 2);

  logic [31:0]        ceiling_r;
  logic [31:0]        floor_r;
  logic signed [10:0] pitch_r;

  rcwc_pkg::state_t   state_r;
  rcwc_pkg::state_t   state_nxt;

  logic [RW-1:0]      row_r;
  logic [31:0]        pos_r;
  logic [31:0]        step_r;
  logic [RW-1:0]      first_r;
  logic [RW-1:0]      end_r;
  rcwc_pkg::face_t    face_r;
  logic [5:0]         texel_r;
  logic [23:0]        dist_r;
  logic [SW-1:0]      offset_r;

  logic               out_valid_r;
  rcwc_pkg::kind_t    out_kind_r;
  logic [31:0]        out_color_r;
  logic [1:0]         out_tsel_r;
  logic [5:0]         out_tcol_r;
  logic [5:0]         out_trow_r;
  logic [23:0]        out_depth_r;
  logic [9:0]         out_start_r;
  logic [8:0]         out_end_r;
  logic [8:0]         out_prow_r;
  logic               out_last_r;

  rcwc_pkg::div_req_t div_req;
  rcwc_pkg::div_res_t div_res;

  logic               in_fire;
  logic               out_free;
  logic               col_fire;
  logic               pix_fire;
  logic               info_load;
  logic [23:0]        dist_clamp;
  rcwc_pkg::face_t    face_in;
  logic [31:0]        texel_prod;

  logic [HW-1:0]      h_now;
  logic [HW-1:0]      half_now;
  logic signed [SW-1:0] half_s;
  logic signed [SW-1:0] c_s;
  logic signed [SW-1:0] start_s;
  logic signed [SW-1:0] end_s;
  logic [RW-1:0]      first_nxt;
  logic [RW-1:0]      end_nxt;
  logic [SW-1:0]      offset_nxt;
  logic [SW+31:0]     pos_prod;

  logic               row_last;
  logic               row_ceiling;
  logic               row_wall;
  logic [15:0]        trow_masked;

  logic               in_div_state;
  logic               span_in_range;

  rcwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign in_item.ready = (state_r == rcwc_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_item.valid && in_item.ready;
  assign out_free = !out_valid_r || out_item.ready;
  assign col_fire = in_fire && (in_item.opcode == rcwc_pkg::OP_COLUMN);
  assign pix_fire = in_fire && (in_item.opcode == rcwc_pkg::OP_PIXEL);

  always_comb begin
    dist_clamp = (in_item.wall_distance < rcwc_pkg::MIN_DIST) ?
                 rcwc_pkg::MIN_DIST : in_item.wall_distance;
    if (in_item.hit_side == 1'b0) begin
      face_in = in_item.ray_dir_x_positive ? rcwc_pkg::FACE_WEST : rcwc_pkg::FACE_EAST;
    end else begin
      face_in = in_item.ray_dir_y_positive ? rcwc_pkg::FACE_SOUTH : rcwc_pkg::FACE_NORTH;
    end
    texel_prod = 32'(in_item.wall_hit_fraction) * 32'(TEX_COLUMNS);
  end

  always_comb begin
    h_now    = div_res.quotient[HW:1];
    half_now = h_now >> 1;
    half_s   = $signed(SW'(half_now));
    c_s      = CENTRE_S + SW'(pitch_r);
    start_s  = c_s - half_s;
    end_s    = c_s + half_s;
    if (start_s < 0) begin
      first_nxt  = '0;
      offset_nxt = SW'(half_s - c_s);
    end else begin
      first_nxt  = (start_s > SH_S) ? RW'(SCREEN_HEIGHT) : start_s[RW-1:0];
      offset_nxt = '0;
    end
    if (end_s >= SH_S) begin
      end_nxt = RW'(SCREEN_HEIGHT - 1);
    end else if (end_s < 0) begin
      end_nxt = '0;
    end else begin
      end_nxt = end_s[RW-1:0];
    end
    pos_prod = offset_r * step_r;
  end

  always_comb begin
    row_last    = (row_r >= RW'(SCREEN_HEIGHT - 1));
    row_ceiling = (row_r < first_r);
    row_wall    = !row_ceiling && (row_r < end_r);
    trow_masked = pos_r[31:16] & 16'(TEX_ROWS - 1);
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = H_DIVIDEND;
    div_req.divisor  = dist_clamp;
    info_load        = 1'b0;
    unique case (state_r)
      rcwc_pkg::ST_IDLE: begin
        if (col_fire) begin
          div_req.start = 1'b1;
          state_nxt     = rcwc_pkg::ST_DIV_H;
        end
      end
      rcwc_pkg::ST_DIV_H: begin
        if (div_res.done) begin
          if (h_now == '0) begin
            state_nxt = rcwc_pkg::ST_MUL;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = STEP_DIVIDEND;
            div_req.divisor  = rcwc_pkg::DIV_DW'(h_now);
            state_nxt        = rcwc_pkg::ST_DIV_STEP;
          end
        end
      end
      rcwc_pkg::ST_DIV_STEP: begin
        if (div_res.done) begin
          state_nxt = rcwc_pkg::ST_MUL;
        end
      end
      rcwc_pkg::ST_MUL: begin
        state_nxt = rcwc_pkg::ST_RESULT;
      end
      rcwc_pkg::ST_RESULT: begin
        if (out_free) begin
          info_load = 1'b1;
          state_nxt = rcwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcwc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= '0;
      floor_r   <= '0;
      pitch_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcwc_pkg::CFG_CEILING: ceiling_r <= cfg_wdata;
        rcwc_pkg::CFG_FLOOR:   floor_r   <= cfg_wdata;
        rcwc_pkg::CFG_PITCH:   pitch_r   <= $signed(cfg_wdata[10:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      pos_r   <= '0;
      step_r  <= '0;
      first_r <= '0;
      end_r   <= '0;
      face_r  <= rcwc_pkg::FACE_NORTH;
      texel_r <= '0;
    end else begin
      if (col_fire) begin
        row_r   <= '0;
        face_r  <= face_in;
        texel_r <= texel_prod[21:16];
      end
      if (state_r == rcwc_pkg::ST_DIV_H && div_res.done) begin
        first_r <= first_nxt;
        end_r   <= end_nxt;
        step_r  <= '0;
      end
      if (state_r == rcwc_pkg::ST_DIV_STEP && div_res.done) begin
        step_r <= div_res.quotient;
      end
      if (state_r == rcwc_pkg::ST_MUL) begin
        pos_r <= pos_prod[31:0];
      end
      if (pix_fire) begin
        row_r <= row_last ? '0 : row_r + 1'b1;
        if (row_wall) begin
          pos_r <= pos_r + step_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_fire) begin
      dist_r <= dist_clamp;
    end
    if (state_r == rcwc_pkg::ST_DIV_H && div_res.done) begin
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_fire || info_load) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (info_load) begin
      out_kind_r  <= rcwc_pkg::KIND_COLUMN;
      out_color_r <= '0;
      out_tsel_r  <= face_r;
      out_tcol_r  <= texel_r;
      out_trow_r  <= '0;
      out_depth_r <= dist_r;
      out_start_r <= 10'(first_r);
      out_end_r   <= 9'(end_r);
      out_prow_r  <= '0;
      out_last_r  <= 1'b0;
    end else if (pix_fire) begin
      out_start_r <= 10'(first_r);
      out_end_r   <= 9'(end_r);
      out_prow_r  <= 9'(row_r);
      out_last_r  <= row_last;
      out_depth_r <= '0;
      if (row_ceiling) begin
        out_kind_r  <= rcwc_pkg::KIND_CEILING;
        out_color_r <= ceiling_r;
        out_tsel_r  <= '0;
        out_tcol_r  <= '0;
        out_trow_r  <= '0;
      end else if (row_wall) begin
        out_kind_r  <= rcwc_pkg::KIND_WALL;
        out_color_r <= '0;
        out_tsel_r  <= face_r;
        out_tcol_r  <= texel_r;
        out_trow_r  <= trow_masked[5:0];
      end else begin
        out_kind_r  <= rcwc_pkg::KIND_FLOOR;
        out_color_r <= floor_r;
        out_tsel_r  <= '0;
        out_tcol_r  <= '0;
        out_trow_r  <= '0;
      end
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.kind           = out_kind_r;
  assign out_item.color          = out_color_r;
  assign out_item.texture_select = out_tsel_r;
  assign out_item.texel_column   = out_tcol_r;
  assign out_item.texel_row      = out_trow_r;
  assign out_item.depth_clamped  = out_depth_r;
  assign out_item.span_start     = out_start_r;
  assign out_item.span_end       = out_end_r;
  assign out_item.pixel_row      = out_prow_r;
  assign out_item.last_row       = out_last_r;

  assign in_div_state  = (state_r == rcwc_pkg::ST_DIV_H) || (state_r == rcwc_pkg::ST_DIV_STEP);
  assign span_in_range = (first_r <= RW'(SCREEN_HEIGHT)) && (end_r < RW'(SCREEN_HEIGHT));

  `RCWC_ASSERT_NEXT(a_column_blocks_input, col_fire, !in_item.ready, "input not blocked")
  `RCWC_ASSERT_NOW(a_div_done_in_div, div_res.done, in_div_state, "divider done outside a divide")
  `RCWC_ASSERT_NOW(a_span_bounds, 1'b1, span_in_range, "wall span out of range")

endmodule

// File: dv/raycast_column_span_checker.sv
`timescale 1ns / 1ps

module raycast_column_span_checker #(
  parameter int SCREEN_H = 512,
  parameter int TEX_H    = 64,
  parameter int TEX_W    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  rcwc_in_if          in_mon,
  rcwc_out_if         out_mon,
  output int          mismatch_count,
  output int          rows_outstanding
);

  typedef struct packed {
    rcwc_pkg::kind_t kind;
    logic [31:0]     color;
    rcwc_pkg::face_t face;
    logic [5:0]      tex_col;
    logic [5:0]      tex_row;
    logic [23:0]     depth;
    logic [9:0]      span_start;
    logic [8:0]      span_end;
    logic [8:0]      row;
    logic            last;
  } span_out_t;

  logic [31:0]        ceiling_rgb;
  logic [31:0]        floor_rgb;
  logic signed [10:0] pitch_q;

  logic [9:0]      row_q;
  logic [31:0]     tex_pos_q;
  logic [31:0]     tex_step_q;
  logic [9:0]      first_row_q;
  logic [9:0]      end_row_q;
  rcwc_pkg::face_t face_q;
  logic [5:0]      tex_col_q;

  span_out_t awaited_spans[$];
  int        results_seen;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on result %0d: %s", $time, results_seen, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, %0h expected", name, got, want));
    end
  endtask

  // Advances the column state by one item and returns the result it produces: the column info or a row.
  function automatic span_out_t step_column_span(
    input logic op, input logic [23:0] dist_in, input logic [15:0] frac,
    input logic side, input logic x_pos, input logic y_pos
  );
    span_out_t   r;
    int unsigned dist_q;
    int          h, half, c, start, stop;
    logic [9:0]  y;
    logic        last;

    r = '0;
    if (op == rcwc_pkg::OP_COLUMN) begin
      dist_q = dist_in;
      if (dist_q < rcwc_pkg::MIN_DIST) begin
        dist_q = rcwc_pkg::MIN_DIST;
      end
      h = int'(((64'(SCREEN_H) << 16) / 64'(dist_q)) >> 1);
      half = h / 2;
      c = SCREEN_H / 2 + int'(pitch_q);
      start = c - half;
      if (start < 0) begin
        start = 0;
      end
      stop = c + half;
      if (stop >= SCREEN_H) begin
        stop = SCREEN_H - 1;
      end
      if (stop < 0) begin
        stop = 0;
      end
      tex_step_q = (h == 0) ? 32'd0 : 32'((64'(TEX_H) << 16) / 64'(h));
      tex_pos_q = 32'(start - c + half) * tex_step_q;
      first_row_q = (start > SCREEN_H) ? 10'(SCREEN_H) : 10'(start);
      end_row_q = 10'(stop);
      if (side == 1'b0) begin
        face_q = x_pos ? rcwc_pkg::FACE_WEST : rcwc_pkg::FACE_EAST;
      end else begin
        face_q = y_pos ? rcwc_pkg::FACE_SOUTH : rcwc_pkg::FACE_NORTH;
      end
      tex_col_q = 6'((32'(frac) * TEX_W) >> 16);
      row_q = '0;
      r.kind = rcwc_pkg::KIND_COLUMN;
      r.face = face_q;
      r.tex_col = tex_col_q;
      r.depth = dist_q[23:0];
    end else begin
      y = row_q;
      last = (y >= SCREEN_H - 1);
      if (y < first_row_q) begin
        r.kind = rcwc_pkg::KIND_CEILING;
        r.color = ceiling_rgb;
      end else if (y < end_row_q) begin
        r.kind = rcwc_pkg::KIND_WALL;
        r.face = face_q;
        r.tex_col = tex_col_q;
        r.tex_row = 6'((tex_pos_q >> 16) & (TEX_H - 1));
        tex_pos_q = tex_pos_q + tex_step_q;
      end else begin
        r.kind = rcwc_pkg::KIND_FLOOR;
        r.color = floor_rgb;
      end
      r.row = y[8:0];
      r.last = last;
      row_q = last ? 10'd0 : y + 10'd1;
    end
    r.span_start = first_row_q;
    r.span_end = end_row_q[8:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    span_out_t got;
    span_out_t want;

    if (!rst_n) begin
      ceiling_rgb <= '0;
      floor_rgb <= '0;
      pitch_q <= '0;
      row_q = '0;
      tex_pos_q = '0;
      tex_step_q = '0;
      first_row_q = '0;
      end_row_q = '0;
      face_q = rcwc_pkg::FACE_NORTH;
      tex_col_q = '0;
      awaited_spans.delete();
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcwc_pkg::CFG_CEILING: ceiling_rgb <= cfg_wdata;
          rcwc_pkg::CFG_FLOOR:   floor_rgb <= cfg_wdata;
          rcwc_pkg::CFG_PITCH:   pitch_q <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind = rcwc_pkg::kind_t'(out_mon.kind);
        got.color = out_mon.color;
        got.face = rcwc_pkg::face_t'(out_mon.texture_select);
        got.tex_col = out_mon.texel_column;
        got.tex_row = out_mon.texel_row;
        got.depth = out_mon.depth_clamped;
        got.span_start = out_mon.span_start;
        got.span_end = out_mon.span_end;
        got.row = out_mon.pixel_row;
        got.last = out_mon.last_row;
        if (awaited_spans.size() == 0) begin
          report_mismatch("result arrived with no item outstanding");
        end else begin
          want = awaited_spans.pop_front();
          check_field("kind", 32'(got.kind), 32'(want.kind));
          check_field("color", got.color, want.color);
          check_field("texture_select", 32'(got.face), 32'(want.face));
          check_field("texel_column", 32'(got.tex_col), 32'(want.tex_col));
          check_field("texel_row", 32'(got.tex_row), 32'(want.tex_row));
          check_field("depth_clamped", 32'(got.depth), 32'(want.depth));
          check_field("span_start", 32'(got.span_start), 32'(want.span_start));
          check_field("span_end", 32'(got.span_end), 32'(want.span_end));
          check_field("pixel_row", 32'(got.row), 32'(want.row));
          check_field("last_row", 32'(got.last), 32'(want.last));
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_spans.push_back(step_column_span(
          in_mon.opcode, in_mon.wall_distance, in_mon.wall_hit_fraction,
          in_mon.hit_side, in_mon.ray_dir_x_positive, in_mon.ray_dir_y_positive));
      end
    end
    rows_outstanding <= awaited_spans.size();
  end

endmodule

// File: dv/raycast_wall_column_span_top_tb.sv
`timescale 1ns / 1ps

module raycast_wall_column_span_top_tb;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        calm;
  int          stall_cycles;
  int          mismatches;
  int          rows_outstanding;
  int          items_sent = 0;

  rcwc_in_if  in_item ();
  rcwc_out_if out_item ();

  always #5 clk = ~clk;

  raycast_wall_column_span_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .out_item (out_item)
  );

  raycast_column_span_checker column_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mon          (in_item),
    .out_mon         (out_item),
    .mismatch_count  (mismatches),
    .rows_outstanding(rows_outstanding)
  );

  always @(posedge clk) begin
    out_item.ready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_item.valid && in_item.ready) ||
        (out_item.valid && out_item.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send(input logic op, input logic [23:0] wall_dist,
                      input logic [15:0] frac, input logic side, input logic x_pos,
                      input logic y_pos);
    while (!calm && $urandom_range(99) < 19) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.opcode <= op;
    in_item.wall_distance <= wall_dist;
    in_item.wall_hit_fraction <= frac;
    in_item.hit_side <= side;
    in_item.ray_dir_x_positive <= x_pos;
    in_item.ray_dir_y_positive <= y_pos;
    do @(posedge clk); while (!in_item.ready);
    items_sent++;
  endtask

  task automatic send_pixels(input int n);
    repeat (n) begin
      send(rcwc_pkg::OP_PIXEL, 24'($urandom), 16'($urandom), 1'($urandom),
           1'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    in_item.valid <= 1'b0;
    do @(posedge clk); while (rows_outstanding != 0);
  endtask

  task automatic write_settings(input logic [31:0] ceiling_rgb,
                                input logic [31:0] floor_rgb, input int pitch);
    cfg_we <= 1'b1;
    cfg_index <= rcwc_pkg::CFG_CEILING;
    cfg_wdata <= ceiling_rgb;
    @(posedge clk);
    cfg_index <= rcwc_pkg::CFG_FLOOR;
    cfg_wdata <= floor_rgb;
    @(posedge clk);
    cfg_index <= rcwc_pkg::CFG_PITCH;
    cfg_wdata <= {21'd0, 11'(pitch)};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          phase_end;
    int          rows;
    int          pick;
    logic [23:0] wall_dist;

    rst_n <= 1'b0;
    calm <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rcwc_pkg::CFG_CEILING;
    cfg_wdata <= '0;
    in_item.valid <= 1'b0;
    in_item.opcode <= rcwc_pkg::OP_COLUMN;
    in_item.wall_distance <= '0;
    in_item.wall_hit_fraction <= '0;
    in_item.hit_side <= 1'b0;
    in_item.ray_dir_x_positive <= 1'b0;
    in_item.ray_dir_y_positive <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Rows asked for before any column fall on the empty span left by reset.
    send_pixels(2);
    drain();

    // With the horizon far up, near walls start at the top row.
    write_settings($urandom, $urandom, -512);
    send(rcwc_pkg::OP_COLUMN, 24'd0, 16'h0000, 1'b0, 1'b1, 1'b0);
    send_pixels(3);
    send(rcwc_pkg::OP_COLUMN, 24'd6553, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_pixels(1);
    send(rcwc_pkg::OP_COLUMN, rcwc_pkg::MIN_DIST, 16'h8000, 1'b1, 1'b0, 1'b1);
    send(rcwc_pkg::OP_COLUMN, 24'hFFFFFF, 16'h03FF, 1'b1, 1'b1, 1'b0);
    send_pixels(2);
    send(rcwc_pkg::OP_COLUMN, 24'h010000, 16'h0400, 1'b0, 1'b1, 1'b1);
    send_pixels(1);
    drain();

    // With the horizon far down, a distant wall starts below the screen.
    write_settings(32'hFFFFFFFF, 32'h00000000, 512);
    send(rcwc_pkg::OP_COLUMN, rcwc_pkg::MIN_DIST, 16'h5555, 1'b1, 1'b1, 1'b1);
    send_pixels(2);
    send(rcwc_pkg::OP_COLUMN, 24'hFFFFFF, 16'hAAAA, 1'b0, 1'b0, 1'b0);
    send_pixels(2);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_settings(32'h00000000, 32'hFFFFFFFF, 0);
        1: write_settings($urandom, $urandom, -512);
        2: write_settings($urandom, $urandom, 512);
        default: write_settings($urandom, $urandom, int'($urandom_range(1024)) - 512);
      endcase
      calm <= (phase == 0);
      phase_end = items_sent + 10;
      while (items_sent < phase_end) begin
        pick = $urandom_range(9);
        if (pick < 4) begin
          wall_dist = 24'($urandom);
        end else if (pick < 8) begin
          wall_dist = 24'($urandom_range(24'h030000));
        end else begin
          wall_dist = 24'($urandom_range(8000));
        end
        send(rcwc_pkg::OP_COLUMN, wall_dist, 16'($urandom), 1'($urandom),
             1'($urandom), 1'($urandom));
        pick = $urandom_range(99);
        if (phase == 0 && items_sent < phase_end - 8) begin
          // One column runs past the bottom row so that the row count wraps.
          rows = 513;
        end else if (pick < 80) begin
          rows = $urandom_range(16);
        end else begin
          rows = $urandom_range(32, 17);
        end
        send_pixels(rows);
      end
      drain();
    end

    calm <= 1'b0;
    repeat (8) @(posedge clk);
    if (mismatches == 0 && rows_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rcwc_pkg.sv
rtl/core/rcwc_in_if.sv
rtl/core/rcwc_out_if.sv
rtl/core/rcwc_div.sv
rtl/core/raycast_wall_column_span_top.sv
dv/raycast_column_span_checker.sv
dv/raycast_wall_column_span_top_tb.sv
